// ----- rtl/core/dvbe_pkg.sv -----
package dvbe_pkg;

  localparam logic [15:0] YearBase = 16'd2000;
  localparam logic [15:0] YearLast = 16'd2099;
  localparam logic [7:0]  PmFlag   = 8'h20;
  localparam logic [7:0]  HourLast = 8'd23;
  localparam logic [7:0]  MinLast  = 8'd59;
  localparam logic [7:0]  SecLast  = 8'd59;
  localparam logic [7:0]  WdayLast = 8'd6;
  localparam logic [7:0]  MonLast  = 8'd12;
  localparam logic [3:0]  MonFeb   = 4'd2;

  typedef struct packed {
    logic [15:0] full_year;
    logic [7:0]  month_num;
    logic [7:0]  day_of_month;
    logic [7:0]  hour_24;
    logic [7:0]  minute_num;
    logic [7:0]  second_num;
    logic [7:0]  weekday_num;
  } dvbe_in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  seconds_bcd;
    logic [7:0]  minutes_bcd;
    logic [7:0]  hour_reg;
    logic [7:0]  day_bcd;
    logic [7:0]  month_bcd;
    logic [7:0]  year_bcd;
    logic [7:0]  weekday_bcd;
  } dvbe_out_t;

  // Days in month; zero for a month number that means nothing.
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] days;
    unique case (mon) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      MonFeb:                                     days = leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  // Packed BCD of 0..99: tens by multiply with 103/1024, exact over that range.
  function automatic logic [7:0] to_bcd(input logic [6:0] val);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = 14'(val) * 14'd103;
    tens     = prod[13:10];
    tens_x10 = 7'(tens) * 7'd10;
    ones     = val - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// ----- rtl/core/datetime_validate_bcd_encode.sv -----
// Input transfers are registered in stage 1, then stage 2, then stage 3.
// Throughput: one item per cycle while out_stall_i is low; three register
// stages (range check and hour mapping, day check and BCD conversion, error
// masking) each hold one item. A stall on the output holds stage 3 and every
// full stage directly behind it; a stage behind a bubble still advances into it.
// Reset (rst_ni low, asynchronous) empties all stages; payload is not reset.
module datetime_validate_bcd_encode import dvbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dvbe_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dvbe_out_t out_data_o
);

  typedef struct packed {
    logic       err;
    logic [4:0] max_day;
    logic [7:0] day;
    logic [6:0] year_off;
    logic [3:0] mon;
    logic [3:0] hour12;
    logic       pm;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
  } s1_t;

  typedef struct packed {
    logic       err;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_reg;
    logic [7:0] day_bcd;
    logic [7:0] mon_bcd;
    logic [7:0] year_bcd;
    logic [7:0] wday_bcd;
  } s2_t;

  logic      v1_q, v2_q, v3_q;
  logic      en1, en2, en3;
  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  dvbe_out_t s3_d, s3_q;

  // Advance a stage when it is empty or its successor advances.
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  // Stage 1: field range checks, year offset, 12-hour mapping.
  always_comb begin
    logic [15:0] yoff;
    logic        year_ok;
    logic [7:0]  hr;
    yoff    = in_data_i.full_year - YearBase;
    year_ok = (in_data_i.full_year >= YearBase) && (in_data_i.full_year <= YearLast);
    hr      = in_data_i.hour_24;
    // Within 2000..2099 the leap rule reduces to divisibility by four.
    s1_d.max_day  = month_days(in_data_i.month_num[3:0], yoff[1:0] == 2'd0);
    s1_d.err      = !year_ok
                 || (in_data_i.month_num == 8'd0) || (in_data_i.month_num > MonLast)
                 || (hr > HourLast)
                 || (in_data_i.minute_num > MinLast)
                 || (in_data_i.second_num > SecLast)
                 || (in_data_i.weekday_num > WdayLast);
    s1_d.day      = in_data_i.day_of_month;
    s1_d.year_off = yoff[6:0];
    s1_d.mon      = in_data_i.month_num[3:0];
    if (hr == 8'd0) begin
      s1_d.hour12 = 4'd12;
      s1_d.pm     = 1'b0;
    end else if (hr < 8'd12) begin
      s1_d.hour12 = hr[3:0];
      s1_d.pm     = 1'b0;
    end else if (hr == 8'd12) begin
      s1_d.hour12 = 4'd12;
      s1_d.pm     = 1'b1;
    end else begin
      s1_d.hour12 = 4'(hr - 8'd12);
      s1_d.pm     = 1'b1;
    end
    s1_d.minute = in_data_i.minute_num[5:0];
    s1_d.second = in_data_i.second_num[5:0];
    s1_d.wday   = in_data_i.weekday_num[2:0];
  end

  // Stage 2: day bound check and BCD conversion.
  always_comb begin
    logic day_ok;
    day_ok        = (s1_q.day != 8'd0) && (s1_q.day <= {3'd0, s1_q.max_day});
    s2_d.err      = s1_q.err || !day_ok;
    s2_d.sec_bcd  = to_bcd({1'b0, s1_q.second});
    s2_d.min_bcd  = to_bcd({1'b0, s1_q.minute});
    s2_d.hour_reg = to_bcd({3'd0, s1_q.hour12}) | (s1_q.pm ? PmFlag : 8'h00);
    s2_d.day_bcd  = to_bcd({2'd0, s1_q.day[4:0]});
    s2_d.mon_bcd  = to_bcd({3'd0, s1_q.mon});
    s2_d.year_bcd = to_bcd(s1_q.year_off);
    s2_d.wday_bcd = to_bcd({4'd0, s1_q.wday});
  end

  // Stage 3: zero all bytes on error.
  always_comb begin
    s3_d.status = s2_q.err;
    if (s2_q.err) begin
      s3_d.seconds_bcd = 8'h00;
      s3_d.minutes_bcd = 8'h00;
      s3_d.hour_reg    = 8'h00;
      s3_d.day_bcd     = 8'h00;
      s3_d.month_bcd   = 8'h00;
      s3_d.year_bcd    = 8'h00;
      s3_d.weekday_bcd = 8'h00;
    end else begin
      s3_d.seconds_bcd = s2_q.sec_bcd;
      s3_d.minutes_bcd = s2_q.min_bcd;
      s3_d.hour_reg    = s2_q.hour_reg;
      s3_d.day_bcd     = s2_q.day_bcd;
      s3_d.month_bcd   = s2_q.mon_bcd;
      s3_d.year_bcd    = s2_q.year_bcd;
      s3_d.weekday_bcd = s2_q.wday_bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import dvbe_pkg::*;

  localparam int IdlePct     = 29;
  localparam int RandItems   = 1000;
  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;

  localparam dvbe_out_t ErrResult = '{status: 1'b1, default: '0};

  typedef struct {
    dvbe_in_t  stim;
    bit        typed;
    dvbe_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  dvbe_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  dvbe_out_t out_data_o;

  dvbe_out_t pending_regs[$];
  int        fail_cnt     = 0;
  int        quiet_cycles = 0;
  bit        no_idle      = 1'b0;

  datetime_validate_bcd_encode i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Gregorian month length; zero for a month number outside 1..12.
  function automatic int month_len(int yr, int mon);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (mon < 1 || mon > 12) return 0;
    if (mon == 2 && (yr % 400 == 0 || (yr % 4 == 0 && yr % 100 != 0))) return 29;
    return lens[mon-1];
  endfunction

  function automatic logic [7:0] bcd_byte(int val);
    return 8'((val / 10) * 16 + val % 10);
  endfunction

  function automatic dvbe_out_t calendar_encode(dvbe_in_t d);
    dvbe_out_t r;
    int        yr;
    int        hr12;
    yr = int'(d.full_year);
    if (yr < 2000 || yr > 2099 || d.day_of_month == 0 ||
        int'(d.day_of_month) > month_len(yr, int'(d.month_num)) ||
        d.hour_24 > 23 || d.minute_num > 59 || d.second_num > 59 ||
        d.weekday_num > 6) return ErrResult;
    // 0 and 12 both read as 12 on the clock face
    hr12 = int'(d.hour_24) % 12;
    if (hr12 == 0) hr12 = 12;
    r.status      = 1'b0;
    r.seconds_bcd = bcd_byte(int'(d.second_num));
    r.minutes_bcd = bcd_byte(int'(d.minute_num));
    r.hour_reg    = bcd_byte(hr12) | ((d.hour_24 >= 12) ? 8'h20 : 8'h00);
    r.day_bcd     = bcd_byte(int'(d.day_of_month));
    r.month_bcd   = bcd_byte(int'(d.month_num));
    r.year_bcd    = bcd_byte(yr - 2000);
    r.weekday_bcd = bcd_byte(int'(d.weekday_num));
    return r;
  endfunction

  function automatic dvbe_in_t calendar(int yr, int mon, int day, int hr, int mi, int se,
                                        int wd);
    dvbe_in_t d;
    d.full_year    = 16'(yr);
    d.month_num    = 8'(mon);
    d.day_of_month = 8'(day);
    d.hour_24      = 8'(hr);
    d.minute_num   = 8'(mi);
    d.second_num   = 8'(se);
    d.weekday_num  = 8'(wd);
    return d;
  endfunction

  // Well-formed date with a bias toward the last day of the month.
  function automatic dvbe_in_t random_date();
    int yr;
    int mon;
    int lim;
    int day;
    yr  = $urandom_range(2099, 2000);
    mon = $urandom_range(12, 1);
    lim = month_len(yr, mon);
    day = ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 1);
    return calendar(yr, mon, day, $urandom_range(23), $urandom_range(59),
                    $urandom_range(59), $urandom_range(6));
  endfunction

  task automatic send_item(input dvbe_in_t item, input dvbe_out_t want);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_regs.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin : check_results
    dvbe_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_regs.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        want = pending_regs.pop_front();
        check_field("status", {7'd0, want.status}, {7'd0, out_data_o.status});
        check_field("seconds_bcd", want.seconds_bcd, out_data_o.seconds_bcd);
        check_field("minutes_bcd", want.minutes_bcd, out_data_o.minutes_bcd);
        check_field("hour_reg", want.hour_reg, out_data_o.hour_reg);
        check_field("day_bcd", want.day_bcd, out_data_o.day_bcd);
        check_field("month_bcd", want.month_bcd, out_data_o.month_bcd);
        check_field("year_bcd", want.year_bcd, out_data_o.year_bcd);
        check_field("weekday_bcd", want.weekday_bcd, out_data_o.weekday_bcd);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_table[$];
    dvbe_in_t item;
    int       sel;
    int       lim;

    dir_table = '{
      '{calendar(2000, 1, 1, 0, 0, 0, 0), 1'b1,
        dvbe_out_t'({1'b0, 8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, 8'h00})},
      '{calendar(2099, 12, 31, 23, 59, 59, 6), 1'b1,
        dvbe_out_t'({1'b0, 8'h59, 8'h59, 8'h31, 8'h31, 8'h12, 8'h99, 8'h06})},
      '{calendar(1999, 12, 31, 12, 0, 0, 5), 1'b1, ErrResult},
      '{calendar(2100, 1, 1, 0, 0, 0, 5), 1'b1, ErrResult},
      '{calendar(0, 0, 0, 0, 0, 0, 0), 1'b1, ErrResult},
      '{calendar(65535, 255, 255, 255, 255, 255, 255), 1'b1, ErrResult},
      '{calendar(2050, 0, 1, 8, 0, 0, 1), 1'b1, ErrResult},
      '{calendar(2050, 13, 1, 8, 0, 0, 1), 1'b1, ErrResult},
      '{calendar(2050, 6, 0, 8, 0, 0, 1), 1'b1, ErrResult},
      '{calendar(2000, 2, 29, 6, 15, 45, 2), 1'b0, '0},
      '{calendar(2024, 2, 29, 18, 5, 7, 4), 1'b0, '0},
      '{calendar(2023, 2, 29, 18, 5, 7, 3), 1'b1, ErrResult},
      '{calendar(2000, 2, 30, 1, 1, 1, 1), 1'b1, ErrResult},
      '{calendar(2099, 4, 30, 9, 41, 22, 3), 1'b0, '0},
      '{calendar(2099, 4, 31, 9, 41, 22, 3), 1'b1, ErrResult},
      '{calendar(2030, 7, 4, 12, 30, 15, 4), 1'b0, '0},
      '{calendar(2030, 7, 4, 11, 30, 15, 4), 1'b0, '0},
      '{calendar(2030, 7, 4, 13, 30, 15, 4), 1'b0, '0},
      '{calendar(2030, 7, 4, 24, 30, 15, 4), 1'b1, ErrResult},
      '{calendar(2030, 7, 4, 10, 60, 15, 4), 1'b1, ErrResult},
      '{calendar(2030, 7, 4, 10, 30, 60, 4), 1'b1, ErrResult},
      '{calendar(2030, 7, 4, 10, 30, 15, 7), 1'b1, ErrResult},
      '{calendar(2077, 11, 30, 1, 9, 10, 3), 1'b0, '0},
      '{calendar(2096, 2, 29, 22, 58, 3, 0), 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i].stim,
                dir_table[i].typed ? dir_table[i].want : calendar_encode(dir_table[i].stim));
    end

    for (int n = 0; n < RandItems; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) begin
        // hold off until the pipeline has drained
        in_valid_i <= 1'b0;
        while (pending_regs.size() != 0) @(posedge clk_i);
      end
      sel  = $urandom_range(99);
      item = random_date();
      if (sel >= 90) begin
        item = {$urandom, $urandom};
      end else if (sel >= 70) begin
        // break exactly one field
        case ($urandom_range(6))
          0: item.full_year = $urandom_range(1) ? 16'($urandom_range(1999, 1900))
                                                : 16'($urandom_range(2200, 2100));
          1: item.month_num = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 13));
          2: begin
            lim = month_len(int'(item.full_year), int'(item.month_num));
            item.day_of_month = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, lim + 1));
          end
          3: item.hour_24     = 8'($urandom_range(255, 24));
          4: item.minute_num  = 8'($urandom_range(255, 60));
          5: item.second_num  = 8'($urandom_range(255, 60));
          default: item.weekday_num = 8'($urandom_range(255, 7));
        endcase
      end
      send_item(item, calendar_encode(item));
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (pending_regs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
